// ----- rtl/mqsm_pkg.sv -----
`timescale 1ns / 1ps

package mqsm_pkg;

	// Record width: id in the upper 32 bits, grade in the lower 16 bits.
	localparam int REC_W = 48;

	// Operation codes.
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_CONSUME = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_QFULL = 2'd1;
	localparam logic [1:0] ST_SFULL = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Configuration register indexes, taken from address bit 2.
	localparam logic REG_ACTIVE_QUEUES = 1'b0;
	localparam logic REG_QUEUE_LIMIT   = 1'b1;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         queue_id;
		logic signed [31:0] student_id;
		logic [15:0]        grade;
		logic [9:0]         read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         moved_count;
		logic signed [31:0] entry_student_id;
		logic [15:0]        entry_grade;
		logic [10:0]        sorted_count;
		logic [10:0]        queue_occupancy;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic push;
		logic rd_entry;
		logic take_entry;
		logic set_range;
		logic cons_start;
		logic q_skip;
		logic q_pop;
		logic ins_start;
		logic drop;
		logic s_rd;
		logic s_shift;
		logic s_put;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       idx_ok;
		logic       q_done;
		logic       q_empty;
		logic       s_full;
		logic       pos_zero;
		logic       key_gt;
		logic       out_free;
	} sts_t;

endpackage

// ----- rtl/mqsm_in_if.sv -----
`timescale 1ns / 1ps

interface mqsm_in_if;
	import mqsm_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mqsm_out_if.sv -----
`timescale 1ns / 1ps

interface mqsm_out_if;
	import mqsm_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/multi_queue_sorted_merge.sv -----
`timescale 1ns / 1ps

// Sorted merge of several bounded record queues.
// Requests arrive on in_ch (valid/ready): push a record into a queue, run a
// consume pass, read a sorted entry, or do nothing. Every request gives one
// result on out_ch carrying status, moved count, entry fields, sorted count
// and queue occupancy.
// A consume pass visits each active queue in turn: an empty queue is skipped,
// its record is dropped when the sorted store is full, and otherwise the
// record is popped and inserted by shifting each sorted entry with a larger
// id up one place until the record's slot is found; the shift loop reads
// and writes the sorted memory one entry at a time.
// One request is worked on at a time; the next is taken once the previous
// result sits in the output register, which holds it while out_ch stalls.
// A stall longer than the next request's work holds that request back.
// Reset clears all queue pointers, fills and the sorted count at once; no
// clearing pass is needed. Registers are to be written through the APB port
// only while the block is idle, unenforced: active_queues at 0x0, queue_limit at 0x4.
module multi_queue_sorted_merge #(
	parameter int NUM_QUEUES    = 16,
	parameter int QUEUE_DEPTH   = 1024,
	parameter int SORT_CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mqsm_in_if.sink     in_ch,
	mqsm_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mqsm_pkg::*;

	logic [4:0]  active_q;
	logic [10:0] limit_q;
	cmd_t        cmd;
	sts_t        sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd1;
			limit_q  <= 11'd1024;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_ACTIVE_QUEUES: active_q <= pwdata[4:0];
				REG_QUEUE_LIMIT:   limit_q  <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? 32'(limit_q) : 32'(active_q);
	assign pready = 1'b1;

	mqsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mqsm_dp #(
		.NUM_QUEUES    (NUM_QUEUES),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.SORT_CAPACITY (SORT_CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_data       (in_ch.data),
		.active_queues (active_q),
		.queue_limit   (limit_q),
		.out_valid     (out_ch.valid),
		.out_data      (out_ch.data),
		.out_ready     (out_ch.ready)
	);

endmodule

// ----- rtl/mqsm_ctrl.sv -----
`timescale 1ns / 1ps

module mqsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mqsm_pkg::sts_t sts,
	output mqsm_pkg::cmd_t cmd
);
	import mqsm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUSH,
		S_R_TAKE,
		S_C_CHECK,
		S_C_POP,
		S_I_CHECK,
		S_I_CMP,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_PUSH: state_d = S_PUSH;
					OP_CONSUME: begin
						cmd.cons_start = 1'b1;
						state_d        = S_C_CHECK;
					end
					OP_READ: begin
						if (sts.idx_ok) begin
							cmd.rd_entry = 1'b1;
							state_d      = S_R_TAKE;
						end else begin
							cmd.set_range = 1'b1;
							state_d       = S_FINISH;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_FINISH;
			end
			S_R_TAKE: begin
				cmd.take_entry = 1'b1;
				state_d        = S_FINISH;
			end
			S_C_CHECK: begin
				if (sts.q_done) begin
					state_d = S_FINISH;
				end else if (sts.q_empty) begin
					cmd.q_skip = 1'b1;
				end else begin
					cmd.q_pop = 1'b1;
					state_d   = S_C_POP;
				end
			end
			S_C_POP: begin
				if (sts.s_full) begin
					cmd.drop = 1'b1;
					state_d  = S_C_CHECK;
				end else begin
					cmd.ins_start = 1'b1;
					state_d       = S_I_CHECK;
				end
			end
			S_I_CHECK: begin
				if (sts.pos_zero) begin
					cmd.s_put = 1'b1;
					state_d   = S_C_CHECK;
				end else begin
					cmd.s_rd = 1'b1;
					state_d  = S_I_CMP;
				end
			end
			S_I_CMP: begin
				if (sts.key_gt) begin
					cmd.s_shift = 1'b1;
					state_d     = S_I_CHECK;
				end else begin
					cmd.s_put = 1'b1;
					state_d   = S_C_CHECK;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ----- rtl/mqsm_dp.sv -----
`timescale 1ns / 1ps

module mqsm_dp #(
	parameter int NUM_QUEUES    = 16,
	parameter int QUEUE_DEPTH   = 1024,
	parameter int SORT_CAPACITY = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mqsm_pkg::cmd_t      cmd,
	output mqsm_pkg::sts_t      sts,
	input  mqsm_pkg::in_item_t  in_data,
	input  logic [4:0]          active_queues,
	input  logic [10:0]         queue_limit,
	output logic                out_valid,
	output mqsm_pkg::out_item_t out_data,
	input  logic                out_ready
);
	import mqsm_pkg::*;

	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CW  = (FW > 11) ? FW : 11;
	localparam int IW  = $clog2(NUM_QUEUES + 1);
	localparam int NW  = (IW > 5) ? IW : 5;
	localparam int SW  = $clog2(SORT_CAPACITY);
	localparam int SFW = $clog2(SORT_CAPACITY + 1);
	localparam int RW  = (SFW > 10) ? SFW : 10;
	localparam int QROWS = NUM_QUEUES * (2 ** PW);

	// Queue pointers and fills, sorted fill, scan counters.
	logic [PW-1:0]  qhead_q [NUM_QUEUES];
	logic [PW-1:0]  qtail_q [NUM_QUEUES];
	logic [FW-1:0]  qfill_q [NUM_QUEUES];
	logic [SFW-1:0] sfill_q;
	logic [IW-1:0]  qi_q;
	logic [SFW-1:0] pos_q;
	logic           out_valid_q;

	// Storage and payload registers.
	logic [REC_W-1:0] qmem [QROWS];
	logic [REC_W-1:0] smem [SORT_CAPACITY];
	logic [REC_W-1:0] qdata_q;
	logic [REC_W-1:0] sdata_q;
	logic [REC_W-1:0] rec_q;
	in_item_t         item_q;
	logic [4:0]       moved_q;
	logic             dropped_q;
	logic [1:0]       status_q;
	logic [31:0]      eid_q;
	logic [15:0]      egr_q;
	logic [10:0]      occ_q;
	out_item_t        out_data_q;

	logic [QW-1:0] qsel;
	logic [QW-1:0] qcur;
	logic [CW-1:0] lim_eff;
	logic [NW-1:0] n_eff;
	logic          q_exists;
	logic          push_ok;
	logic [FW-1:0] fill_sel;
	logic [PW-1:0] tail_sel;
	logic [PW-1:0] head_cur;
	logic [SW-1:0] pos_idx;
	logic [SW-1:0] pos_m1;

	// Effective limits and selected queue fields.
	assign qsel     = QW'(item_q.queue_id);
	assign qcur     = qi_q[QW-1:0];
	assign lim_eff  = (int'(queue_limit) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(queue_limit);
	assign n_eff    = (int'(active_queues) > NUM_QUEUES) ? NW'(NUM_QUEUES) : NW'(active_queues);
	assign q_exists = int'(item_q.queue_id) < NUM_QUEUES;
	assign fill_sel = qfill_q[qsel];
	assign tail_sel = qtail_q[qsel];
	assign head_cur = qhead_q[qcur];
	assign push_ok  = q_exists && (CW'(fill_sel) < lim_eff);
	assign pos_idx  = pos_q[SW-1:0];
	assign pos_m1   = SW'(pos_q - 1'b1);

	// Status towards the controller.
	always_comb begin
		sts.op       = item_q.operation;
		sts.idx_ok   = RW'(item_q.read_index) < RW'(sfill_q);
		sts.q_done   = NW'(qi_q) >= n_eff;
		sts.q_empty  = (qfill_q[qcur] == '0);
		sts.s_full   = int'(sfill_q) >= SORT_CAPACITY;
		sts.pos_zero = (pos_q == '0);
		sts.key_gt   = $signed(sdata_q[47:16]) > $signed(rec_q[47:16]);
		sts.out_free = !out_valid_q || out_ready;
	end

	// Pointer, fill and counter updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				qhead_q[i] <= '0;
				qtail_q[i] <= '0;
				qfill_q[i] <= '0;
			end
			sfill_q     <= '0;
			qi_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push && push_ok) begin
				qtail_q[qsel] <= (int'(tail_sel) == QUEUE_DEPTH - 1) ? '0 : tail_sel + 1'b1;
				qfill_q[qsel] <= fill_sel + 1'b1;
			end
			if (cmd.q_pop) begin
				qhead_q[qcur] <= (int'(head_cur) == QUEUE_DEPTH - 1) ? '0 : head_cur + 1'b1;
				qfill_q[qcur] <= qfill_q[qcur] - 1'b1;
			end
			if (cmd.s_put) begin
				sfill_q <= sfill_q + 1'b1;
			end
			if (cmd.cons_start) begin
				qi_q <= '0;
			end else if (cmd.q_skip || cmd.drop || cmd.s_put) begin
				qi_q <= qi_q + 1'b1;
			end
			if (cmd.ins_start) begin
				pos_q <= sfill_q;
			end else if (cmd.s_shift) begin
				pos_q <= pos_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Queue storage: write on push, registered read on pop.
	always_ff @(posedge clk) begin
		if (cmd.push && push_ok) begin
			qmem[{qsel, tail_sel}] <= {item_q.student_id, item_q.grade};
		end
		if (cmd.q_pop) begin
			qdata_q <= qmem[{qcur, head_cur}];
		end
	end

	// Sorted storage: one registered read port, one write port.
	always_ff @(posedge clk) begin
		if (cmd.s_rd) begin
			sdata_q <= smem[pos_m1];
		end else if (cmd.rd_entry) begin
			sdata_q <= smem[SW'(item_q.read_index)];
		end
		if (cmd.s_shift) begin
			smem[pos_idx] <= sdata_q;
		end else if (cmd.s_put) begin
			smem[pos_idx] <= rec_q;
		end
	end

	// Request capture and result fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= in_data;
			status_q  <= ST_OK;
			moved_q   <= '0;
			dropped_q <= 1'b0;
			eid_q     <= '0;
			egr_q     <= '0;
			occ_q     <= '0;
		end
		if (cmd.push) begin
			status_q <= push_ok ? ST_OK : ST_QFULL;
			if (!q_exists) begin
				occ_q <= '0;
			end else if (push_ok) begin
				occ_q <= 11'(fill_sel + 1'b1);
			end else begin
				occ_q <= 11'(fill_sel);
			end
		end
		if (cmd.set_range) begin
			status_q <= ST_RANGE;
		end
		if (cmd.take_entry) begin
			eid_q <= sdata_q[47:16];
			egr_q <= sdata_q[15:0];
		end
		if (cmd.ins_start) begin
			rec_q <= qdata_q;
		end
		if (cmd.drop) begin
			dropped_q <= 1'b1;
		end
		if (cmd.s_put && moved_q != 5'd31) begin
			moved_q <= moved_q + 1'b1;
		end
		if (cmd.finish) begin
			out_data_q.status           <= dropped_q ? ST_SFULL : status_q;
			out_data_q.moved_count      <= moved_q;
			out_data_q.entry_student_id <= eid_q;
			out_data_q.entry_grade      <= egr_q;
			out_data_q.sorted_count     <= 11'(sfill_q);
			out_data_q.queue_occupancy  <= occ_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The sorted store never holds more than its capacity.
	a_sfill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sfill_q) <= SORT_CAPACITY)
		else $error("sorted fill beyond capacity");

	// An insertion is never started into a full sorted store.
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_start |-> !sts.s_full)
		else $error("insertion into full sorted store");

	// A result is only loaded when the output register is free.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

	// A pop only happens on a queue holding records.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_pop |-> !sts.q_empty)
		else $error("pop from empty queue");

endmodule
